@@ rtl/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.

package hsv2rgb_pkg;

    localparam int HUE_W      = 9;
    localparam int CH_W       = 8;
    localparam int SEC_W      = 3;
    localparam int OFS_W      = 7;        // hue offset within a 120-degree pair
    localparam int DIST_W     = 6;        // |offset - 60|, 0..60
    localparam int NUM_W      = 14;       // 15300 - sat * span
    localparam int LO_PROD_W  = 16;       // bri * (255 - sat)
    localparam int PROD_W     = 22;       // bri * (15300 - sat * span)

    localparam int HUE_TURN   = 360;
    localparam int HUE_SECTOR = 60;
    localparam int CH_FULL    = 255;
    localparam int MID_DEN    = CH_FULL * HUE_SECTOR;

    // x / 15300 == (x * RECIP_M) >> RECIP_SHIFT for every x below 2**PROD_W
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_M = 23'd4491470;
    localparam int SCALED_W    = PROD_W + RECIP_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Which channel is max, mid, min in each 60-degree sector
    typedef enum logic [SEC_W-1:0] {
        SEC_RGB = 3'd0,   // R > G > B
        SEC_GRB = 3'd1,   // G > R > B
        SEC_GBR = 3'd2,   // G > B > R
        SEC_BGR = 3'd3,   // B > G > R
        SEC_BRG = 3'd4,   // B > R > G
        SEC_RBG = 3'd5    // R > B > G
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [DIST_W-1:0]   span;
        logic [CH_W-1:0]     sat;
        logic [CH_W-1:0]     bri;
    } hue_stage_t;

    typedef struct packed {
        sector_t             sector;
        logic [CH_W-1:0]     hi;
        logic [CH_W-1:0]     lo;
        logic [SCALED_W-1:0] mid_scaled;
    } scale_stage_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

endpackage

@@ rtl/hsv2rgb_sector.sv @@
// Stage 1: hue wrap, sector decode and distance from the sector pair center.
// Depends on hsv2rgb_pkg.

module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [HUE_W-1:0] hue_degrees,
    input  logic [CH_W-1:0]  saturation,
    input  logic [CH_W-1:0]  brightness,
    output logic             out_valid,
    output hue_stage_t       out_stage
);

    localparam logic [HUE_W-1:0] TURN_C = HUE_W'(HUE_TURN);
    localparam logic [HUE_W-1:0] SEC_C  = HUE_W'(HUE_SECTOR);
    localparam logic [OFS_W-1:0] HALF_C = OFS_W'(HUE_SECTOR);

    logic [HUE_W-1:0] hue_wrap;
    logic [HUE_W-1:0] pair_base;
    logic [HUE_W-1:0] ofs_full;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] dist_full;
    sector_t          sector;
    hue_stage_t       stage_next;
    hue_stage_t       stage_reg;
    logic             valid_reg;

    always_comb
    begin
        hue_wrap = (hue_degrees >= TURN_C) ? hue_degrees - TURN_C : hue_degrees;

        priority if (hue_wrap < SEC_C)
            sector = SEC_RGB;
        else if (hue_wrap < 9'(2 * HUE_SECTOR))
            sector = SEC_GRB;
        else if (hue_wrap < 9'(3 * HUE_SECTOR))
            sector = SEC_GBR;
        else if (hue_wrap < 9'(4 * HUE_SECTOR))
            sector = SEC_BGR;
        else if (hue_wrap < 9'(5 * HUE_SECTOR))
            sector = SEC_BRG;
        else
            sector = SEC_RBG;

        unique case (sector)
            SEC_RGB, SEC_GRB: pair_base = '0;
            SEC_GBR, SEC_BGR: pair_base = 9'(2 * HUE_SECTOR);
            default:          pair_base = 9'(4 * HUE_SECTOR);
        endcase

        ofs_full  = hue_wrap - pair_base;
        ofs       = ofs_full[OFS_W-1:0];
        dist_full = (ofs >= HALF_C) ? ofs - HALF_C : HALF_C - ofs;

        stage_next.sector = sector;
        stage_next.span   = dist_full[DIST_W-1:0];
        stage_next.sat    = saturation;
        stage_next.bri    = brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

@@ rtl/hsv2rgb_scale.sv @@
// Stages 2 to 4: chroma products and the constant divisions by 255 and 15300.
// Depends on hsv2rgb_pkg.

module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  hue_stage_t   in_stage,
    output logic         out_valid,
    output scale_stage_t out_stage
);

    // stage 2: numerators before the brightness product
    logic [NUM_W-1:0]     sd;
    logic [NUM_W-1:0]     num_mid_next;
    logic [CH_W-1:0]      nsat_next;
    logic [NUM_W-1:0]     num_mid_reg;
    logic [CH_W-1:0]      nsat_reg;
    logic [CH_W-1:0]      bri2_reg;
    sector_t              sec2_reg;
    logic                 v2_reg;

    // stage 3: brightness products
    logic [PROD_W-1:0]    pm_next;
    logic [LO_PROD_W-1:0] pl_next;
    logic [PROD_W-1:0]    pm_reg;
    logic [LO_PROD_W-1:0] pl_reg;
    logic [CH_W-1:0]      bri3_reg;
    sector_t              sec3_reg;
    logic                 v3_reg;

    // stage 4: reciprocal product for /15300, add-and-shift for /255
    logic [LO_PROD_W:0]   lo_sum;
    scale_stage_t         s4_next;
    scale_stage_t         s4_reg;
    logic                 v4_reg;

    always_comb
    begin
        sd           = NUM_W'(in_stage.sat) * NUM_W'(in_stage.span);
        num_mid_next = NUM_W'(MID_DEN) - sd;
        nsat_next    = CH_W'(CH_FULL) - in_stage.sat;

        pm_next = PROD_W'(bri2_reg) * PROD_W'(num_mid_reg);
        pl_next = LO_PROD_W'(bri2_reg) * LO_PROD_W'(nsat_reg);

        // x / 255 == (x + (x >> 8) + 1) >> 8 for 16-bit x below 65535
        lo_sum = {1'b0, pl_reg} + (LO_PROD_W + 1)'(pl_reg >> CH_W) + 17'd1;

        s4_next.sector     = sec3_reg;
        s4_next.hi         = bri3_reg;
        s4_next.lo         = lo_sum[CH_W +: CH_W];
        s4_next.mid_scaled = SCALED_W'(pm_reg) * SCALED_W'(RECIP_M);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_mid_reg <= num_mid_next;
            nsat_reg    <= nsat_next;
            bri2_reg    <= in_stage.bri;
            sec2_reg    <= in_stage.sector;
            pm_reg      <= pm_next;
            pl_reg      <= pl_next;
            bri3_reg    <= bri2_reg;
            sec3_reg    <= sec2_reg;
            s4_reg      <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_stage = s4_reg;

endmodule

@@ rtl/hsv2rgb_route.sv @@
// Stage 5: quotient extraction and sector-driven channel routing into the
// output register. Depends on hsv2rgb_pkg.

module hsv2rgb_route
    import hsv2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  scale_stage_t in_stage,
    output logic         out_valid,
    output rgb_t         out_rgb
);

    logic [CH_W-1:0] mid;
    rgb_t            rgb_next;
    rgb_t            rgb_reg;
    logic            valid_reg;

    always_comb
    begin
        mid = in_stage.mid_scaled[RECIP_SHIFT +: CH_W];

        unique case (in_stage.sector)
            SEC_RGB: rgb_next = '{red: in_stage.hi, green: mid,         blue: in_stage.lo};
            SEC_GRB: rgb_next = '{red: mid,         green: in_stage.hi, blue: in_stage.lo};
            SEC_GBR: rgb_next = '{red: in_stage.lo, green: in_stage.hi, blue: mid};
            SEC_BGR: rgb_next = '{red: in_stage.lo, green: mid,         blue: in_stage.hi};
            SEC_BRG: rgb_next = '{red: mid,         green: in_stage.lo, blue: in_stage.hi};
            default: rgb_next = '{red: in_stage.hi, green: in_stage.lo, blue: mid};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rgb_reg <= rgb_next;
    end

    assign out_valid = valid_reg;
    assign out_rgb   = rgb_reg;

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB converter, top level: five-stage pipeline with stream ports.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_scale, hsv2rgb_route.
//
// Usage:
//   Input stream s_axis_*: one transfer carries hue (0..359, larger values
//   wrap by 360), saturation and brightness. Output stream m_axis_*: one
//   transfer per input with red, green, blue and the packed 24-bit word.
//   An input transfer passes through the stage registers of sector, scale
//   and route to m_axis_tvalid. Throughput is one item per clock unless
//   the output stalls; all five stages advance together on one enable.
//   Stall: while m_axis_tvalid is high and m_axis_tready is low the whole
//   pipeline holds, and s_axis_tready is low in the same cycle. Bubbles
//   inside the pipeline do not collapse during a stall.
//   Reset: rst_n clears all stage valid bits; the block accepts input in
//   the first cycle after reset is released. No configuration, no state
//   beyond the pipeline.
//   The longest stage is the 22 x 23 reciprocal multiply for the /15300.

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] hue_degrees, [16:9] saturation, [24:17] brightness, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [47:24] packed_rgb
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic         en;
    logic         v1;
    logic         v4;
    logic         v5;
    hue_stage_t   st1;
    scale_stage_t st4;
    rgb_t         rgb;

    assign en            = !v5 || m_axis_tready;
    assign s_axis_tready = en;

    hsv2rgb_sector u_sector (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .hue_degrees (s_axis_tdata[HUE_W-1:0]),
        .saturation  (s_axis_tdata[HUE_W +: CH_W]),
        .brightness  (s_axis_tdata[HUE_W + CH_W +: CH_W]),
        .out_valid   (v1),
        .out_stage   (st1)
    );

    hsv2rgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .in_stage  (st1),
        .out_valid (v4),
        .out_stage (st4)
    );

    hsv2rgb_route u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4),
        .in_stage  (st4),
        .out_valid (v5),
        .out_rgb   (rgb)
    );

    assign m_axis_tvalid = v5;
    assign m_axis_tdata  = {rgb.red, rgb.green, rgb.blue, rgb.blue, rgb.green, rgb.red};

endmodule

@@ rtl/hsv2rgb_checker.sv @@
// Port-level checks for hsv_to_rgb_converter, attached by bind.
// Depends on hsv2rgb_pkg.

module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    // a blocked output backs up to the input in the same cycle
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output is blocked");

    // packed word matches the separate channels
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[47:24] == {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]})
        else $error("packed_rgb differs from channels");

    // gray input: once the transfer has advanced through every stage without a stall, all channels equal brightness
    a_gray_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[16:9] == 8'd0)
            ##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
        |=> m_axis_tvalid
            && m_axis_tdata[7:0]   == $past(s_axis_tdata[24:17], 5)
            && m_axis_tdata[15:8]  == $past(s_axis_tdata[24:17], 5)
            && m_axis_tdata[23:16] == $past(s_axis_tdata[24:17], 5))
        else $error("zero-saturation result wrong or late");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ bench/tb_hsv_to_rgb_converter.sv @@
// Self-checking bench for hsv_to_rgb_converter: random and corner HSV pixels,
// each converted result checked against a bit-exact integer predictor.
// Depends on rtl/hsv2rgb_pkg.sv and rtl/hsv_to_rgb_converter.sv.

module tb_hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [CH_W-1:0]  bri;
        logic [CH_W-1:0]  sat;
        logic [HUE_W-1:0] hue;
    } hsv_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    hsv_t hsv_send_q[$];
    rgb_t rgb_expect_q[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    int   hold_left = 0;
    int   mismatch_count = 0;

    hsv_to_rgb_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Exact integer HSV to RGB, channels truncated toward zero
    function automatic rgb_t hsv_pixel_to_rgb(hsv_t px);
        int unsigned     h, s, v, t, span;
        logic [CH_W-1:0] top, bottom, middle;
        sector_t         sec;
        rgb_t            c;
        h = 32'(px.hue);
        if (h >= HUE_TURN)
            h = h - HUE_TURN;
        s = 32'(px.sat);
        v = 32'(px.bri);
        top = CH_W'(v);
        bottom = CH_W'((v * (CH_FULL - s)) / CH_FULL);
        t = h % (2 * HUE_SECTOR);
        span = (t >= HUE_SECTOR) ? t - HUE_SECTOR : HUE_SECTOR - t;
        middle = CH_W'((v * (MID_DEN - s * span)) / MID_DEN);
        sec = sector_t'(SEC_W'(h / HUE_SECTOR));
        case (sec)
            SEC_RGB: c = '{red: top,    green: middle, blue: bottom};
            SEC_GRB: c = '{red: middle, green: top,    blue: bottom};
            SEC_GBR: c = '{red: bottom, green: top,    blue: middle};
            SEC_BGR: c = '{red: bottom, green: middle, blue: top};
            SEC_BRG: c = '{red: middle, green: bottom, blue: top};
            default: c = '{red: top,    green: bottom, blue: middle};
        endcase
        return c;
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CH_W'($urandom_range(255));
    endfunction

    function automatic hsv_t rand_pixel();
        hsv_t px;
        // occasional out-of-range hue to exercise the wrap
        if ($urandom_range(9) == 0)
            px.hue = HUE_W'($urandom_range(511, HUE_TURN));
        else
            px.hue = HUE_W'($urandom_range(HUE_TURN - 1));
        px.sat = rand_channel();
        px.bri = rand_channel();
        return px;
    endfunction

    // Input driver: a transfer leaves the send queue and its prediction is queued
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                rgb_expect_q.push_back(hsv_pixel_to_rgb(hsv_send_q.pop_front()));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                offer = (hsv_send_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                s_axis_tvalid <= offer;
                if (offer)
                    s_axis_tdata <= IN_DATA_W'(hsv_send_q[0]);
            end
        end
    end

    // Long receiver hold-off counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Output monitor
    always @(posedge clk)
    begin : check_output
        rgb_t            want;
        logic [CH_W-1:0] got_r, got_g, got_b;
        logic [23:0]     got_word;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r    = m_axis_tdata[7:0];
            got_g    = m_axis_tdata[15:8];
            got_b    = m_axis_tdata[23:16];
            got_word = m_axis_tdata[47:24];
            if (rgb_expect_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h", $time, m_axis_tdata);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                want = rgb_expect_q.pop_front();
                if (got_r !== want.red || got_g !== want.green || got_b !== want.blue
                    || got_word !== want)
                begin
                    $display("%0t: r/g/b/packed expected %h %h %h %h actual %h %h %h %h",
                             $time, want.red, want.green, want.blue, want,
                             got_r, got_g, got_b, got_word);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    task automatic drain();
        while (hsv_send_q.size() != 0 || rgb_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_pixel(int hue, int sat, int bri);
        hsv_t px;
        px.hue = HUE_W'(hue);
        px.sat = CH_W'(sat);
        px.bri = CH_W'(bri);
        hsv_send_q.push_back(px);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            hsv_send_q.push_back(rand_pixel());
        drain();
    endtask

    initial
    begin
        int sector_edges[12];
        sector_edges = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every sector boundary at full color, then corners
        foreach (sector_edges[i])
            send_pixel(sector_edges[i], 255, 255);
        send_pixel(30, 255, 255);           // mid of sector, full chroma
        send_pixel(200, 0, 200);            // no saturation: gray
        send_pixel(90, 0, 255);
        send_pixel(150, 255, 0);            // black
        send_pixel(0, 0, 0);
        send_pixel(360, 255, 255);          // wraps to red
        send_pixel(511, 171, 203);          // wraps to 151
        send_pixel(419, 128, 77);
        send_pixel(270, 1, 1);
        send_pixel(45, 254, 254);
        send_pixel(359, 127, 128);
        drain();

        run_phase(350, 0, 0);
        run_phase(300, 77, 0);
        run_phase(300, 0, 77);
        run_phase(300, 18, 18);

        // Receiver held off while the sender keeps offering: pipeline fills
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_arm = 1'b1;
        @(negedge clk);
        hold_arm = 1'b0;
        repeat (40)
            hsv_send_q.push_back(rand_pixel());
        drain();

        run_phase(100, 30, 30);

        repeat (12) @(negedge clk);
        if (mismatch_count == 0 && rgb_expect_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
